### hw/rtl/rlf_pkg.sv
// Shared types and constants for the RGB LED fade controller.
// Holds the request and result structs, the function codes and the lane interface types.
// No dependencies.
package rlf_pkg;

    localparam int CHANNELS   = 3;
    localparam int MAX_LEVEL  = 10;
    localparam int DUTY_W     = 12;
    localparam int COLOUR_W   = 8;
    localparam int LEVEL_W    = 4;
    localparam int IN_VAL_W   = 10;
    localparam int OUT_CHANS  = 3;
    localparam int SHOWN      = (CHANNELS < OUT_CHANS) ? CHANNELS : OUT_CHANS;

    localparam logic [DUTY_W-1:0]   RAMP_RESET = DUTY_W'(50);
    localparam logic [COLOUR_W-1:0] COLOUR_MAX = COLOUR_W'(255);

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_POWER  = 2'd1,
        FUNC_LEVEL  = 2'd2,
        FUNC_COLOUR = 2'd3
    } func_t;

    typedef struct packed {
        func_t               func;
        logic                power;
        logic [IN_VAL_W-1:0] level;
        logic [IN_VAL_W-1:0] red;
        logic [IN_VAL_W-1:0] green;
        logic [IN_VAL_W-1:0] blue;
    } rlf_req_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  red_duty;
        logic [DUTY_W-1:0]  green_duty;
        logic [DUTY_W-1:0]  blue_duty;
        logic               duty_changed;
        logic               report_state;
        logic               is_on;
        logic [LEVEL_W-1:0] brightness;
    } rlf_res_t;

    // Settings that every lane sees.
    typedef struct packed {
        logic               light_on;
        logic [LEVEL_W-1:0] level;
        logic [DUTY_W-1:0]  step;
    } rlf_lane_cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              moved;
    } rlf_lane_res_t;

endpackage

### hw/rtl/rgb_led_fade_controller.sv
// Top level of the RGB LED fade controller: light settings, channel lanes and the result register.
// Depends on rlf_pkg and rlf_lane.
//
//   channel   valid       stall       payload            use
//   cmd       cmd_valid   cmd_stall   cmd (rlf_req_t)    tick or command request in
//   res       res_valid   res_stall   res (rlf_res_t)    one result per request out
//   config    ramp_step_we  -         ramp_step_wdata    ramp step per tick
//
// All lanes compute the tick in parallel and the result is registered at the
// accepting edge, so one request per cycle is sustained while res_stall is low.
// Reset clears the light state, colours and duties, and sets the ramp step to 50.
// A request is taken when the result register is empty or its result leaves in the
// same cycle; cmd_stall follows res_stall only while a result is held.
module rgb_led_fade_controller
    import rlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  rlf_req_t          cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output rlf_res_t          res,
    input  logic              ramp_step_we,
    input  logic [DUTY_W-1:0] ramp_step_wdata
);

    logic [DUTY_W-1:0]   ramp_step_reg;
    logic                light_on_reg,   light_on_next;
    logic [LEVEL_W-1:0]  level_reg,      level_next;
    logic [COLOUR_W-1:0] colour_reg [CHANNELS];
    logic [COLOUR_W-1:0] colour_next [CHANNELS];
    logic [DUTY_W-1:0]   duty_reg [CHANNELS];
    logic [DUTY_W-1:0]   duty_next [CHANNELS];
    logic                res_valid_reg;
    rlf_res_t            res_reg, res_next;

    rlf_lane_cfg_t       lane_cfg;
    rlf_lane_res_t       lane_res [CHANNELS];
    logic [IN_VAL_W-1:0] req_colour [OUT_CHANS];
    logic [DUTY_W-1:0]   shown_duty [OUT_CHANS];
    logic                accept;
    logic                any_moved;
    logic                all_zero;
    logic                report;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign lane_cfg.light_on = light_on_reg;
    assign lane_cfg.level    = level_reg;
    assign lane_cfg.step     = ramp_step_reg;

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_lane
            rlf_lane u_lane (
                .cfg    (lane_cfg),
                .colour (colour_reg[g]),
                .duty   (duty_reg[g]),
                .res    (lane_res[g])
            );
        end
    endgenerate

    assign req_colour[0] = cmd.red;
    assign req_colour[1] = cmd.green;
    assign req_colour[2] = cmd.blue;

    // Merge the lane flags and work out the next light settings.
    always_comb
    begin
        any_moved = 1'b0;
        all_zero  = 1'b1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            any_moved = any_moved | lane_res[i].moved;
            if (colour_reg[i] != '0)
                all_zero = 1'b0;
        end

        light_on_next = light_on_reg;
        level_next    = level_reg;
        report        = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            colour_next[i] = colour_reg[i];
            duty_next[i]   = duty_reg[i];
        end

        unique case (cmd.func)
            FUNC_TICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                    duty_next[i] = lane_res[i].duty;
            end
            FUNC_POWER:
            begin
                report        = 1'b1;
                light_on_next = cmd.power;
                if (cmd.power && all_zero)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        colour_next[i] = COLOUR_MAX;
                end
            end
            FUNC_LEVEL:
            begin
                if (cmd.level <= IN_VAL_W'(MAX_LEVEL))
                begin
                    level_next    = cmd.level[LEVEL_W-1:0];
                    light_on_next = 1'b1;
                    report        = 1'b1;
                end
            end
            FUNC_COLOUR:
            begin
                for (int i = 0; i < SHOWN; i++)
                begin
                    if (req_colour[i] <= IN_VAL_W'(COLOUR_MAX))
                    begin
                        colour_next[i] = req_colour[i][COLOUR_W-1:0];
                        report         = 1'b1;
                    end
                end
            end
            default:
            begin
                report = 1'b0;
            end
        endcase

        for (int i = 0; i < OUT_CHANS; i++)
            shown_duty[i] = '0;
        for (int i = 0; i < SHOWN; i++)
            shown_duty[i] = duty_next[i];

        res_next.red_duty     = shown_duty[0];
        res_next.green_duty   = shown_duty[1];
        res_next.blue_duty    = shown_duty[2];
        res_next.duty_changed = (cmd.func == FUNC_TICK) && any_moved;
        res_next.report_state = report;
        res_next.is_on        = light_on_next;
        res_next.brightness   = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg <= RAMP_RESET;
            light_on_reg  <= 1'b0;
            level_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                colour_reg[i] <= '0;
                duty_reg[i]   <= '0;
            end
        end
        else
        begin
            if (ramp_step_we)
                ramp_step_reg <= ramp_step_wdata;
            if (accept)
            begin
                light_on_reg <= light_on_next;
                level_reg    <= level_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    colour_reg[i] <= colour_next[i];
                    duty_reg[i]   <= duty_next[i];
                end
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

endmodule

### hw/rtl/rlf_lane.sv
// One channel of the fader: computes the duty after a tick and whether it moved.
// Purely combinational; depends on rlf_pkg.
module rlf_lane
    import rlf_pkg::*;
(
    input  rlf_lane_cfg_t       cfg,
    input  logic [COLOUR_W-1:0] colour,
    input  logic [DUTY_W-1:0]   duty,
    output rlf_lane_res_t       res
);

    logic [DUTY_W-1:0] target;
    logic [DUTY_W-1:0] colour_ext;
    logic [DUTY_W-1:0] gap_down;
    logic [DUTY_W-1:0] gap_up;

    // Colour times level is at most 255 * 15, which fits in the duty width.
    assign target     = DUTY_W'(colour) * DUTY_W'(cfg.level);
    assign colour_ext = DUTY_W'(colour);
    assign gap_down   = duty - target;
    assign gap_up     = target - duty;

    always_comb
    begin
        res.duty  = duty;
        res.moved = 1'b0;
        if (!cfg.light_on)
        begin
            if (duty != '0)
            begin
                res.moved = 1'b1;
                res.duty  = (colour != '0 && duty >= colour_ext) ? duty - colour_ext : '0;
            end
        end
        else if (duty > target)
        begin
            res.moved = 1'b1;
            res.duty  = (gap_down >= cfg.step) ? duty - cfg.step : target;
        end
        else if (duty < target)
        begin
            res.moved = 1'b1;
            res.duty  = (gap_up >= cfg.step) ? duty + cfg.step : target;
        end
    end

endmodule

### sim/rlf_fade_checker.sv
`timescale 1ns / 100ps
// Checker for the RGB LED fade controller: watches the request, result and ramp step
// ports, predicts each result from its own light state and compares results in order.
// Depends on rlf_pkg.
module rlf_fade_checker
    import rlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  rlf_req_t          cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  rlf_res_t          res,
    input  logic              ramp_step_we,
    input  logic [DUTY_W-1:0] ramp_step_wdata,
    output int                pending,
    output int                fail_count
);

    logic                light_on_s;
    logic [LEVEL_W-1:0]  level_s;
    logic [DUTY_W-1:0]   step_s;
    logic [COLOUR_W-1:0] colour_s [CHANNELS];
    logic [DUTY_W-1:0]   duty_s [CHANNELS];
    rlf_res_t            expected_results [$];
    rlf_res_t            oldest;
    int                  errors;

    // Updates the light state for one request and returns the result it causes.
    function automatic rlf_res_t apply_request(input rlf_req_t r);
        rlf_res_t            o;
        logic [IN_VAL_W-1:0] vals [3];
        logic                moved;
        logic                accepted;
        logic                all_zero;
        int                  d;
        int                  c;
        int                  tgt;
        int                  stp;
        o        = '0;
        moved    = 1'b0;
        accepted = 1'b0;
        vals[0]  = r.red;
        vals[1]  = r.green;
        vals[2]  = r.blue;
        stp      = int'(step_s);
        case (r.func)
            FUNC_TICK:
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    d = int'(duty_s[ch]);
                    c = int'(colour_s[ch]);
                    if (!light_on_s)
                    begin
                        // Fading out: drop by the colour value, or to zero if dark or under it.
                        if (d != 0)
                        begin
                            duty_s[ch] = (c != 0 && d >= c) ? DUTY_W'(d - c) : '0;
                            moved = 1'b1;
                        end
                    end
                    else
                    begin
                        tgt = c * int'(level_s);
                        if (d > tgt)
                        begin
                            duty_s[ch] = (d - tgt >= stp) ? DUTY_W'(d - stp) : DUTY_W'(tgt);
                            moved = 1'b1;
                        end
                        else if (d < tgt)
                        begin
                            duty_s[ch] = (tgt - d >= stp) ? DUTY_W'(d + stp) : DUTY_W'(tgt);
                            moved = 1'b1;
                        end
                    end
                end
            end
            FUNC_POWER:
            begin
                if (r.power)
                begin
                    all_zero = 1'b1;
                    for (int ch = 0; ch < CHANNELS; ch++)
                        if (colour_s[ch] != '0)
                            all_zero = 1'b0;
                    if (all_zero)
                        for (int ch = 0; ch < CHANNELS; ch++)
                            colour_s[ch] = COLOUR_MAX;
                    light_on_s = 1'b1;
                end
                else
                begin
                    light_on_s = 1'b0;
                end
                accepted = 1'b1;
            end
            FUNC_LEVEL:
            begin
                if (int'(r.level) <= MAX_LEVEL)
                begin
                    level_s    = r.level[LEVEL_W-1:0];
                    light_on_s = 1'b1;
                    accepted   = 1'b1;
                end
            end
            FUNC_COLOUR:
            begin
                for (int ch = 0; ch < CHANNELS && ch < 3; ch++)
                    if (vals[ch] <= IN_VAL_W'(COLOUR_MAX))
                    begin
                        colour_s[ch] = vals[ch][COLOUR_W-1:0];
                        accepted = 1'b1;
                    end
            end
            default:
            begin
            end
        endcase
        o.red_duty     = duty_s[0];
        o.green_duty   = duty_s[1];
        o.blue_duty    = duty_s[2];
        o.duty_changed = moved;
        o.report_state = accepted;
        o.is_on        = light_on_s;
        o.brightness   = level_s;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [DUTY_W-1:0] want,
                               input logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_on_s = 1'b0;
            level_s    = '0;
            step_s     = RAMP_RESET;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                colour_s[ch] = '0;
                duty_s[ch]   = '0;
            end
            expected_results.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (ramp_step_we)
                step_s = ramp_step_wdata;
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("red_duty", oldest.red_duty, res.red_duty);
                    check_field("green_duty", oldest.green_duty, res.green_duty);
                    check_field("blue_duty", oldest.blue_duty, res.blue_duty);
                    check_field("duty_changed", oldest.duty_changed, res.duty_changed);
                    check_field("report_state", oldest.report_state, res.report_state);
                    check_field("is_on", oldest.is_on, res.is_on);
                    check_field("brightness", oldest.brightness, res.brightness);
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_results.push_back(apply_request(cmd));
            pending    <= expected_results.size();
            fail_count <= errors;
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the RGB LED fade controller: clock, reset, request stimulus,
// result back-pressure and ramp step writes. Depends on rlf_pkg and rlf_fade_checker.
module tb;
    import rlf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    rlf_req_t          cmd;
    logic              res_valid;
    logic              res_stall;
    rlf_res_t          res;
    logic              ramp_step_we;
    logic [DUTY_W-1:0] ramp_step_wdata;
    int                pending;
    int                fail_count;

    bit                tx_quiet;
    bit                rx_quiet;
    bit                long_hold;

    rgb_led_fade_controller i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .ramp_step_we    (ramp_step_we),
        .ramp_step_wdata (ramp_step_wdata)
    );

    rlf_fade_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .ramp_step_we    (ramp_step_we),
        .ramp_step_wdata (ramp_step_wdata),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rlf_req_t make_req(input func_t f, input logic p,
                                          input logic [IN_VAL_W-1:0] lv,
                                          input logic [IN_VAL_W-1:0] r,
                                          input logic [IN_VAL_W-1:0] g,
                                          input logic [IN_VAL_W-1:0] b);
        rlf_req_t q;
        q.func  = f;
        q.power = p;
        q.level = lv;
        q.red   = r;
        q.green = g;
        q.blue  = b;
        return q;
    endfunction

    // Mostly ticks so that the duties have time to ramp, with commands mixed in.
    // Levels and colours are mostly in range; the rest are random, mostly out of range and ignored.
    function automatic rlf_req_t random_req();
        rlf_req_t q;
        int       pick;
        q.power = 1'($urandom);
        q.level = IN_VAL_W'($urandom);
        q.red   = IN_VAL_W'($urandom);
        q.green = IN_VAL_W'($urandom);
        q.blue  = IN_VAL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            q.func = FUNC_TICK;
        end
        else if (pick < 65)
        begin
            q.func = FUNC_POWER;
        end
        else if (pick < 80)
        begin
            q.func = FUNC_LEVEL;
            if ($urandom_range(0, 3) != 0)
                q.level = IN_VAL_W'($urandom_range(0, MAX_LEVEL));
        end
        else
        begin
            q.func = FUNC_COLOUR;
            if ($urandom_range(0, 4) != 0)
                q.red = IN_VAL_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0)
                q.green = IN_VAL_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) != 0)
                q.blue = IN_VAL_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                q.red = '0;
        end
        return q;
    endfunction

    task automatic send_req(input rlf_req_t r);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= r;
        do @(posedge clk); while (cmd_stall);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_req(random_req());
    endtask

    // The step register may only change once every request has delivered its result.
    task automatic write_step(input logic [DUTY_W-1:0] value);
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        ramp_step_we    <= 1'b1;
        ramp_step_wdata <= value;
        @(posedge clk);
        ramp_step_we <= 1'b0;
    endtask

    // Result side: a random hold-off before each result, or one long hold when asked.
    initial
    begin : result_sink
        int wait_cycles;
        res_stall <= 1'b0;
        forever
        begin
            if (long_hold)
            begin
                res_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                wait_cycles = rx_quiet ? 0 : $urandom_range(0, 16);
                if (wait_cycles > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial
    begin
        #4_000_000;
        $display("rgb_led_fade_controller test failed");
        $finish;
    end

    initial
    begin : stimulus
        int drain_cycles;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        long_hold = 1'b0;
        rst_n           <= 1'b0;
        cmd_valid       <= 1'b0;
        cmd             <= '0;
        ramp_step_we    <= 1'b0;
        ramp_step_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset step of 50.
        send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));
        // Power on with every colour at zero turns the light white.
        send_req(make_req(FUNC_POWER, 1'b1, '0, '0, '0, '0));
        send_req(make_req(FUNC_LEVEL, 1'b0, 10'd11, '0, '0, '0));
        send_req(make_req(FUNC_LEVEL, 1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
        send_req(make_req(FUNC_LEVEL, 1'b0, 10'd10, '0, '0, '0));
        repeat (3) send_req(make_req(FUNC_TICK, 1'b1, 10'd1023, '0, '0, '0));
        send_req(make_req(FUNC_COLOUR, 1'b0, '0, 10'd0, 10'd255, 10'd1023));
        // A colour request with every value out of range is not reported.
        send_req(make_req(FUNC_COLOUR, 1'b1, '0, 10'd256, 10'd1023, 10'd300));
        repeat (2) send_req(make_req(FUNC_TICK, 1'b0, '0, 10'd1023, 10'd1023, 10'd1023));
        send_req(make_req(FUNC_LEVEL, 1'b0, 10'd0, '0, '0, '0));
        send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));
        send_req(make_req(FUNC_POWER, 1'b0, 10'd1023, '0, '0, '0));
        repeat (2) send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));
        // Power on with a colour already set keeps the colours.
        send_req(make_req(FUNC_POWER, 1'b1, '0, '0, '0, '0));
        send_req(make_req(FUNC_LEVEL, 1'b0, 10'd1, '0, '0, '0));
        send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));
        send_req(make_req(FUNC_COLOUR, 1'b0, '0, 10'd0, 10'd0, 10'd0));
        send_req(make_req(FUNC_POWER, 1'b0, '0, '0, '0, '0));
        send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));
        send_req(make_req(FUNC_POWER, 1'b1, '0, '0, '0, '0));
        send_req(make_req(FUNC_LEVEL, 1'b0, 10'd10, '0, '0, '0));
        send_req(make_req(FUNC_TICK, 1'b0, '0, '0, '0, '0));

        write_step(DUTY_W'(1));
        run_random(100);

        write_step(DUTY_W'(3825));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random(100);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // With a step of zero the duties hold while the light is on, yet the change flag still rises.
        write_step(DUTY_W'(0));
        run_random(60);

        write_step(DUTY_W'(4095));
        run_random(60);
        long_hold = 1'b1;
        tx_quiet  = 1'b1;
        run_random(40);
        tx_quiet = 1'b0;

        repeat (3)
        begin
            write_step(DUTY_W'($urandom_range(1, 3825)));
            rx_quiet = ($urandom_range(0, 2) == 0);
            run_random(110);
        end
        rx_quiet = 1'b0;

        cmd_valid <= 1'b0;
        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (pending != 0 && drain_cycles < 5000);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rgb_led_fade_controller test passed");
        else
            $display("rgb_led_fade_controller test failed");
        $finish;
    end

endmodule
